/* sv/tgms_pkg.sv */
// ----------------------------------------------------------------------------
// Tactile grip motion sequencer package
// Shared widths, codes, register layout and fixed-point helpers.
// ----------------------------------------------------------------------------
package tgms_pkg;

    localparam int NUM_CELLS_DEF = 18;
    localparam int FRAC_BITS_DEF = 8;

    localparam int CELL_W     = 16;
    localparam int IDX_W      = 5;
    localparam int POS_W      = 24;
    localparam int SUM_OUT_W  = 21;
    localparam int CORR_W     = 10;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 8;

    localparam logic signed [31:0] POS_HI = (32'sd1 <<< (POS_W - 1)) - 32'sd1;
    localparam logic signed [31:0] POS_LO = -POS_HI - 32'sd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT  = 3'd0,
        MODE_FORCE = 3'd1,
        MODE_TURN  = 3'd2,
        MODE_LIFT  = 3'd3,
        MODE_BACK  = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET       = 3'd0,
        REG_GAIN_P       = 3'd1,
        REG_GAIN_I       = 3'd2,
        REG_GAIN_D       = 3'd3,
        REG_TURN_STEP    = 3'd4,
        REG_HALF_TURN    = 3'd5,
        REG_LIFT_PER_DEG = 3'd6,
        REG_INIT_TICKS   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [CELL_W-1:0] goal_height;
        logic [CFG_DATA_W-1:0]    gain_p;
        logic [CFG_DATA_W-1:0]    gain_i;
        logic [CFG_DATA_W-1:0]    gain_d;
        logic [CFG_DATA_W-1:0]    turn_step;
        logic [CFG_DATA_W-1:0]    half_turn_angle;
        logic [CFG_DATA_W-1:0]    lift_per_degree;
        logic [TICK_W-1:0]        init_ticks;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        goal_height:     16'sd384,
        gain_p:          16'd51,
        gain_i:          16'd0,
        gain_d:          16'd51,
        turn_step:       16'd171,
        half_turn_angle: 16'd6912,
        lift_per_degree: 16'd78,
        init_ticks:      8'd72
    };

    // Sequencer view of one tick, carried alongside the PID terms
    typedef struct packed {
        t_mode                       mode;
        logic signed [POS_W-1:0]     left_y;
        logic signed [POS_W-1:0]     left_angle;
        logic signed [SUM_OUT_W-1:0] height_sum;
        logic                        nudge;
    } t_snap;

    // Error width: one bit above the running sum of all cells
    function automatic int err_w(input int num_cells);
        return CELL_W + $clog2(num_cells + 1) + 1;
    endfunction

    // Rest position of the left finger, 135.0 before saturation
    function automatic longint base_full(input int frac_bits);
        return 64'sd135 <<< frac_bits;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [31:0] v);
        if (v > POS_HI) begin
            return POS_HI[POS_W-1:0];
        end
        if (v < POS_LO) begin
            return POS_LO[POS_W-1:0];
        end
        return v[POS_W-1:0];
    endfunction

endpackage

/* sv/tgms_if.sv */
// ----------------------------------------------------------------------------
// Tactile grip motion sequencer channels
// Request, result and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tgms_in_if;
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic [tgms_pkg::IDX_W-1:0]         cell_index;
    logic signed [tgms_pkg::CELL_W-1:0] cell_value;

    modport source(output valid, func, cell_index, cell_value, input ready);
    modport sink(input valid, func, cell_index, cell_value, output ready);
endinterface

interface tgms_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [tgms_pkg::MODE_W-1:0]           mode;
    logic signed [tgms_pkg::POS_W-1:0]     left_y;
    logic signed [tgms_pkg::POS_W-1:0]     left_angle;
    logic signed [tgms_pkg::POS_W-1:0]     right_x;
    logic signed [tgms_pkg::SUM_OUT_W-1:0] height_sum;
    logic signed [tgms_pkg::CORR_W-1:0]    correction;

    modport source(output valid, mode, left_y, left_angle, right_x, height_sum, correction,
                   input ready);
    modport sink(input valid, mode, left_y, left_angle, right_x, height_sum, correction,
                 output ready);
endinterface

interface tgms_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tgms_pkg::CFG_IDX_W-1:0]    index;
    logic [tgms_pkg::CFG_DATA_W-1:0]   data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* sv/tgms_cfg.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the register file and the derived lift step and lift limit.
// ----------------------------------------------------------------------------
module tgms_cfg #(
    parameter int FRAC_BITS = tgms_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tgms_cfg_if.sink             i_cfg,
    output tgms_pkg::t_cfg       o_cfg,
    output logic [31-FRAC_BITS:0] o_lift,
    output logic signed [31:0]   o_y_limit
);

    localparam longint BASE = tgms_pkg::base_full(FRAC_BITS);

    tgms_pkg::t_cfg           r_cfg;
    logic [31-FRAC_BITS:0]    r_lift;
    logic signed [31:0]       r_y_limit;
    logic [31:0]              n_lift_prod;
    logic [31:0]              n_thr_prod;
    logic signed [31:0]       n_y_limit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tgms_pkg::CFG_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tgms_pkg::REG_TARGET:       r_cfg.goal_height     <= $signed(i_cfg.data);
                tgms_pkg::REG_GAIN_P:       r_cfg.gain_p          <= i_cfg.data;
                tgms_pkg::REG_GAIN_I:       r_cfg.gain_i          <= i_cfg.data;
                tgms_pkg::REG_GAIN_D:       r_cfg.gain_d          <= i_cfg.data;
                tgms_pkg::REG_TURN_STEP:    r_cfg.turn_step       <= i_cfg.data;
                tgms_pkg::REG_HALF_TURN:    r_cfg.half_turn_angle <= i_cfg.data;
                tgms_pkg::REG_LIFT_PER_DEG: r_cfg.lift_per_degree <= i_cfg.data;
                tgms_pkg::REG_INIT_TICKS:   r_cfg.init_ticks <= i_cfg.data[tgms_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // (Y - base) << F > H * L holds exactly when Y > base + floor(H * L >> F)
    always_comb begin
        n_lift_prod = 32'(r_cfg.turn_step) * 32'(r_cfg.lift_per_degree);
        n_thr_prod  = 32'(r_cfg.half_turn_angle) * 32'(r_cfg.lift_per_degree);
        n_y_limit   = $signed(32'(BASE)) + $signed(n_thr_prod >> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        r_lift    <= n_lift_prod[31:FRAC_BITS];
        r_y_limit <= n_y_limit;
    end

    assign o_cfg     = r_cfg;
    assign o_lift    = r_lift;
    assign o_y_limit = r_y_limit;

endmodule

/* sv/tgms_state.sv */
// ----------------------------------------------------------------------------
// Cell store and sequencer
// Registers requests, keeps cells and running sum, shifts the error history
// and steps the motion modes; passes tick terms on to the PID stage.
// ----------------------------------------------------------------------------
module tgms_state #(
    parameter int NUM_CELLS = tgms_pkg::NUM_CELLS_DEF,
    parameter int FRAC_BITS = tgms_pkg::FRAC_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    tgms_in_if.sink                                       i_in,
    input  tgms_pkg::t_cfg                                i_cfg,
    input  logic [31-FRAC_BITS:0]                         i_lift,
    input  logic signed [31:0]                            i_y_limit,
    input  logic                                          i_s1_ready,
    output logic                                          o_s1_valid,
    output logic signed [tgms_pkg::err_w(NUM_CELLS)-1:0]  o_err,
    output logic signed [tgms_pkg::err_w(NUM_CELLS)+1:0]  o_esum,
    output logic signed [tgms_pkg::err_w(NUM_CELLS)+1:0]  o_ediff,
    output tgms_pkg::t_snap                               o_snap
);

    localparam int E_W    = tgms_pkg::err_w(NUM_CELLS);
    localparam int SUM_W  = E_W - 1;
    localparam int X_W    = E_W + 2;
    localparam int CIDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int POS_W  = tgms_pkg::POS_W;

    localparam logic signed [POS_W-1:0] Y_RESET =
        tgms_pkg::sat_pos(32'(tgms_pkg::base_full(FRAC_BITS)));

    // Request register
    logic                              r_in_valid;
    logic                              r_in_func;
    logic [tgms_pkg::IDX_W-1:0]        r_in_idx;
    logic signed [tgms_pkg::CELL_W-1:0] r_in_val;

    // Block state
    logic signed [tgms_pkg::CELL_W-1:0] r_cells [NUM_CELLS];
    logic signed [SUM_W-1:0]           r_sum;
    logic signed [E_W-1:0]             r_e1;
    logic signed [E_W-1:0]             r_e2;
    tgms_pkg::t_mode                   r_mode;
    logic [tgms_pkg::TICK_W-1:0]       r_init_cnt;
    logic signed [POS_W-1:0]           r_y;
    logic signed [POS_W-1:0]           r_angle;

    // Tick stage
    logic                              r_s1_valid;
    logic signed [E_W-1:0]             r_err;
    logic signed [X_W-1:0]             r_esum;
    logic signed [X_W-1:0]             r_ediff;
    tgms_pkg::t_snap                   r_snap;

    logic                              s1_free;
    logic                              take;
    logic                              tick;
    logic                              cell_ok;
    logic [CIDX_W-1:0]                 cidx;
    logic signed [SUM_W-1:0]           n_sum;
    logic signed [E_W-1:0]             n_err;
    logic signed [X_W-1:0]             n_esum;
    logic signed [X_W-1:0]             n_ediff;
    tgms_pkg::t_mode                   n_mode;
    logic [tgms_pkg::TICK_W-1:0]       n_init_cnt;
    logic signed [POS_W-1:0]           n_y;
    logic signed [POS_W-1:0]           n_angle;
    logic                              n_nudge;
    logic signed [31:0]                lift_ext;
    logic signed [31:0]                step_ext;

    assign s1_free    = !r_s1_valid || i_s1_ready;
    // A cell write never waits; a tick waits for room in the tick stage
    assign take       = r_in_valid && (!r_in_func || s1_free);
    assign tick       = take && r_in_func;
    assign i_in.ready = !r_in_valid || take;

    assign cell_ok = 32'(r_in_idx) < NUM_CELLS;
    assign cidx    = CIDX_W'(r_in_idx);
    assign n_sum   = r_sum + SUM_W'(r_in_val) - SUM_W'(r_cells[cidx]);

    always_comb begin
        n_err   = E_W'(i_cfg.goal_height) - E_W'(r_sum);
        n_esum  = X_W'(n_err) + X_W'(r_e1) + X_W'(r_e2);
        n_ediff = X_W'(n_err) - (X_W'(r_e1) <<< 1) + X_W'(r_e2);
    end

    assign lift_ext = $signed(32'(i_lift));
    assign step_ext = $signed(32'(i_cfg.turn_step));

    always_comb begin
        n_mode     = r_mode;
        n_init_cnt = r_init_cnt;
        n_y        = r_y;
        n_angle    = r_angle;
        n_nudge    = 1'b0;
        case (r_mode)
            tgms_pkg::MODE_INIT: begin
                if (r_init_cnt >= i_cfg.init_ticks) begin
                    n_mode = tgms_pkg::MODE_FORCE;
                end else begin
                    n_init_cnt = r_init_cnt + 1'b1;
                end
            end
            tgms_pkg::MODE_FORCE: begin
                n_nudge = n_err > 0;
                n_mode  = tgms_pkg::MODE_TURN;
            end
            tgms_pkg::MODE_TURN: begin
                n_angle = tgms_pkg::sat_pos(32'(r_angle) + step_ext);
                if (32'(n_angle) > $signed(32'(i_cfg.half_turn_angle))) begin
                    n_mode = tgms_pkg::MODE_LIFT;
                end
            end
            tgms_pkg::MODE_LIFT: begin
                n_y = tgms_pkg::sat_pos(32'(r_y) + lift_ext);
                if (32'(n_y) > i_y_limit) begin
                    n_mode = tgms_pkg::MODE_BACK;
                end
            end
            tgms_pkg::MODE_BACK: begin
                n_angle = tgms_pkg::sat_pos(32'(r_angle) - step_ext);
                n_y     = tgms_pkg::sat_pos(32'(r_y) - lift_ext);
                if (n_angle[POS_W-1]) begin
                    n_mode = tgms_pkg::MODE_TURN;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_func <= i_in.func;
            r_in_idx  <= i_in.cell_index;
            r_in_val  <= i_in.cell_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CELLS; i++) begin
                r_cells[i] <= '0;
            end
            r_sum      <= '0;
            r_e1       <= '0;
            r_e2       <= '0;
            r_mode     <= tgms_pkg::MODE_INIT;
            r_init_cnt <= '0;
            r_y        <= Y_RESET;
            r_angle    <= '0;
        end else if (tick) begin
            r_e2       <= r_e1;
            r_e1       <= n_err;
            r_mode     <= n_mode;
            r_init_cnt <= n_init_cnt;
            r_y        <= n_y;
            r_angle    <= n_angle;
        end else if (take && cell_ok) begin
            r_cells[cidx] <= r_in_val;
            r_sum         <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_err             <= n_err;
            r_esum            <= n_esum;
            r_ediff           <= n_ediff;
            r_snap.mode       <= n_mode;
            r_snap.left_y     <= n_y;
            r_snap.left_angle <= n_angle;
            r_snap.height_sum <= tgms_pkg::SUM_OUT_W'(r_sum);
            r_snap.nudge      <= n_nudge;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_err      = r_err;
    assign o_esum     = r_esum;
    assign o_ediff    = r_ediff;
    assign o_snap     = r_snap;

endmodule

/* sv/tgms_pid.sv */
// ----------------------------------------------------------------------------
// PID correction and result register
// Registers the three gain products, then sums, clamps, nudges right X and
// holds the result until it is taken.
// ----------------------------------------------------------------------------
module tgms_pid #(
    parameter int NUM_CELLS = tgms_pkg::NUM_CELLS_DEF,
    parameter int FRAC_BITS = tgms_pkg::FRAC_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_s1_valid,
    output logic                                          o_s1_ready,
    input  logic signed [tgms_pkg::err_w(NUM_CELLS)-1:0]  i_err,
    input  logic signed [tgms_pkg::err_w(NUM_CELLS)+1:0]  i_esum,
    input  logic signed [tgms_pkg::err_w(NUM_CELLS)+1:0]  i_ediff,
    input  tgms_pkg::t_snap                               i_snap,
    input  tgms_pkg::t_cfg                                i_cfg,
    tgms_out_if.source                                    o_out
);

    localparam int E_W   = tgms_pkg::err_w(NUM_CELLS);
    localparam int X_W   = E_W + 2;
    localparam int P_W   = E_W + tgms_pkg::CFG_DATA_W + 1;
    localparam int Q_W   = X_W + tgms_pkg::CFG_DATA_W + 1;
    localparam int ACC_W = Q_W + 2;
    localparam int C_W   = FRAC_BITS + 2;
    localparam int POS_W = tgms_pkg::POS_W;

    localparam logic signed [ACC_W-1:0] LIM = $signed(ACC_W'(1)) <<< (2 * FRAC_BITS);
    localparam logic signed [C_W-1:0]   ONE = $signed(C_W'(1)) <<< FRAC_BITS;

    logic                      r_s2_valid;
    logic signed [P_W-1:0]     r_pp;
    logic signed [Q_W-1:0]     r_pi;
    logic signed [Q_W-1:0]     r_pd;
    tgms_pkg::t_snap           r_s2_snap;

    logic                      r_out_valid;
    tgms_pkg::t_mode           r_out_mode;
    logic signed [POS_W-1:0]   r_out_y;
    logic signed [POS_W-1:0]   r_out_angle;
    logic signed [tgms_pkg::SUM_OUT_W-1:0] r_out_sum;
    logic signed [C_W-1:0]     r_out_corr;
    logic signed [POS_W-1:0]   r_right_x;

    logic                      out_free;
    logic                      s2_free;
    logic                      load_out;
    logic signed [P_W-1:0]     n_pp;
    logic signed [Q_W-1:0]     n_pi;
    logic signed [Q_W-1:0]     n_pd;
    logic signed [ACC_W-1:0]   acc;
    logic signed [C_W-1:0]     n_corr;
    logic signed [POS_W-1:0]   n_right_x;

    assign out_free   = !r_out_valid || o_out.ready;
    assign s2_free    = !r_s2_valid || out_free;
    assign load_out   = r_s2_valid && out_free;
    assign o_s1_ready = s2_free;

    always_comb begin
        n_pp = $signed({1'b0, i_cfg.gain_p}) * i_err;
        n_pi = $signed({1'b0, i_cfg.gain_i}) * i_esum;
        n_pd = $signed({1'b0, i_cfg.gain_d}) * i_ediff;
    end

    always_comb begin
        acc = ACC_W'(r_pp) + ACC_W'(r_pi) + ACC_W'(r_pd);
        if (acc > LIM) begin
            n_corr = ONE;
        end else if (acc < -LIM) begin
            n_corr = -ONE;
        end else begin
            n_corr = C_W'(acc >>> FRAC_BITS);
        end
        n_right_x = tgms_pkg::sat_pos(32'(r_right_x) - 32'(n_corr));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && i_s1_valid) begin
            r_pp      <= n_pp;
            r_pi      <= n_pi;
            r_pd      <= n_pd;
            r_s2_snap <= i_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_right_x   <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_s2_valid;
            end
            // Nudge right X only on the force-control tick with sum below target
            if (load_out && r_s2_snap.nudge) begin
                r_right_x <= n_right_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_mode  <= r_s2_snap.mode;
            r_out_y     <= r_s2_snap.left_y;
            r_out_angle <= r_s2_snap.left_angle;
            r_out_sum   <= r_s2_snap.height_sum;
            r_out_corr  <= n_corr;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.mode       = r_out_mode;
    assign o_out.left_y     = r_out_y;
    assign o_out.left_angle = r_out_angle;
    assign o_out.right_x    = r_right_x;
    assign o_out.height_sum = r_out_sum;
    assign o_out.correction = tgms_pkg::CORR_W'(r_out_corr);

endmodule

/* sv/tactile_grip_motion_sequencer.sv */
// ----------------------------------------------------------------------------
// Tactile grip motion sequencer
// Keeps tactile cells with a running sum, forms a clamped PID correction on
// each control tick and steps the init/force/turn/lift/turn-back sequence.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the request channel is not
// stalled. A cell write updates the cell store and the running sum and gives
// no result; a control tick gives one result via the request register, the
// error and sequencer stage and the gain product stage into the result
// register, where the correction is summed, clamped and applied to right X.
// The three gain multipliers are registered in the gain product stage. While
// a result waits to be taken the earlier stages keep filling, and the request
// channel stalls only once they are all full. Register writes land in the
// register file; the lift step and lift limit follow in the cycle after.
module tactile_grip_motion_sequencer #(
    parameter int NUM_CELLS = tgms_pkg::NUM_CELLS_DEF,
    parameter int FRAC_BITS = tgms_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tgms_in_if.sink     i_in,
    tgms_cfg_if.sink    i_cfg,
    tgms_out_if.source  o_out
);

    localparam int E_W   = tgms_pkg::err_w(NUM_CELLS);
    localparam int POS_W = tgms_pkg::POS_W;

    localparam logic signed [POS_W-1:0] Y_RESET =
        tgms_pkg::sat_pos(32'(tgms_pkg::base_full(FRAC_BITS)));

    tgms_pkg::t_cfg           cfg;
    logic [31-FRAC_BITS:0]    lift;
    logic signed [31:0]       y_limit;
    logic                     s1_valid;
    logic                     s1_ready;
    logic signed [E_W-1:0]    err;
    logic signed [E_W+1:0]    esum;
    logic signed [E_W+1:0]    ediff;
    tgms_pkg::t_snap          snap;

    tgms_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_cfg     (cfg),
        .o_lift    (lift),
        .o_y_limit (y_limit)
    );

    tgms_state #(
        .NUM_CELLS (NUM_CELLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (cfg),
        .i_lift     (lift),
        .i_y_limit  (y_limit),
        .i_s1_ready (s1_ready),
        .o_s1_valid (s1_valid),
        .o_err      (err),
        .o_esum     (esum),
        .o_ediff    (ediff),
        .o_snap     (snap)
    );

    tgms_pid #(
        .NUM_CELLS (NUM_CELLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_pid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .o_s1_ready (s1_ready),
        .i_err      (err),
        .i_esum     (esum),
        .i_ediff    (ediff),
        .i_snap     (snap),
        .i_cfg      (cfg),
        .o_out      (o_out)
    );

    // A stalled tick stage must keep its tick
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_valid && !s1_ready |=> s1_valid)
        else $error("tick stage dropped a stalled tick");

    // Before the first force-control step neither finger has moved
    a_idle_x_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.mode == tgms_pkg::MODE_INIT || o_out.mode == tgms_pkg::MODE_FORCE)
        |-> o_out.right_x == '0 && o_out.left_angle == '0)
        else $error("finger moved before force control");

    a_idle_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.mode == tgms_pkg::MODE_INIT || o_out.mode == tgms_pkg::MODE_FORCE)
        |-> o_out.left_y == Y_RESET)
        else $error("left Y left its rest position before lift");

endmodule
